/* hw/rtl/gnos_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnos_pkg
// Shared types, widths and codes for the gradient noise octave sum block.
// ----------------------------------------------------------------------------
package gnos_pkg;

  localparam int TBL_AW    = 8;   // table address bits (256 entries)
  localparam int PERM_W    = 8;
  localparam int GRAD_W    = 16;  // Q1.15 gradient component
  localparam int FRAC_W    = 16;  // Q0.16 lattice fraction
  localparam int PT_W      = 24;  // low point bits that reach cell and fraction
  localparam int CORNER_W  = 20;  // corner value and lerp result, Q.16
  localparam int WGT_W     = 17;  // smoothstep weight, 0..65536
  localparam int TERM_W    = 22;
  localparam int ACC_W     = 34;
  localparam int OCT_W     = 4;
  localparam int OCT_IDX_W = 3;
  localparam int MAX_OCT   = 8;
  localparam int RES_W     = 24;
  localparam int CFG_W     = 4;

  localparam logic [1:0] OP_LOAD_PERM = 2'd0;
  localparam logic [1:0] OP_LOAD_GRAD = 2'd1;
  localparam logic [1:0] OP_EVAL      = 2'd2;
  localparam logic [1:0] OP_SPARE     = 2'd3;  // ignored, no result

  localparam logic [1:0] MODE_TURB    = 2'd0;
  localparam logic [1:0] MODE_FRACTAL = 2'd1;
  localparam logic [1:0] MODE_SINGLE  = 2'd2;
  localparam logic [1:0] MODE_SPARE   = 2'd3;  // acts as single octave

  localparam logic CFG_OCT_COUNT = 1'b0;
  localparam logic CFG_SUM_MODE  = 1'b1;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gz;
    logic signed [GRAD_W-1:0] gy;
    logic signed [GRAD_W-1:0] gx;
  } grad_t;

  typedef struct packed {
    logic              perm_we;
    logic              grad_we;
    logic [TBL_AW-1:0] addr;
    logic [PERM_W-1:0] perm_val;
    grad_t             grad;
  } tbl_wr_t;

endpackage

/* hw/rtl/gnos_tables.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnos_tables
// Permutation and gradient memories: one write port, one registered read each.
// ----------------------------------------------------------------------------
module gnos_tables (
  input  logic                         clk,
  input  gnos_pkg::tbl_wr_t            wr,
  input  logic [gnos_pkg::TBL_AW-1:0]  perm_raddr,
  output logic [gnos_pkg::PERM_W-1:0]  perm_rdata,
  input  logic [gnos_pkg::TBL_AW-1:0]  grad_raddr,
  output gnos_pkg::grad_t              grad_rdata
);

  localparam int DEPTH = 1 << gnos_pkg::TBL_AW;

  logic [gnos_pkg::PERM_W-1:0] perm_mem [DEPTH];
  gnos_pkg::grad_t             grad_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.perm_we) begin
      perm_mem[wr.addr] <= wr.perm_val;
    end
    perm_rdata <= perm_mem[perm_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr.grad_we) begin
      grad_mem[wr.addr] <= wr.grad;
    end
    grad_rdata <= grad_mem[grad_raddr];
  end

endmodule

/* hw/rtl/gnos_weight.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnos_weight
// Three-stage smoothstep pipeline: w = round((3t^2*2^16 - 2t^3) / 2^32).
// ----------------------------------------------------------------------------
module gnos_weight (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  logic [1:0]                   in_tag,
  input  logic [gnos_pkg::FRAC_W-1:0]  in_t,
  output logic                         out_vld,
  output logic [1:0]                   out_tag,
  output logic [gnos_pkg::WGT_W-1:0]   out_w
);

  logic        s1_vld_r, s2_vld_r, s3_vld_r;
  logic [1:0]  s1_tag_r, s2_tag_r, s3_tag_r;
  logic [15:0] s1_t_r;
  logic [31:0] s1_t2_r, s2_t2_r;
  logic [47:0] s2_t3_r;
  logic [16:0] s3_w_r;
  logic [49:0] v;

  always_comb begin
    v = ({18'd0, s2_t2_r} << 16) + ({18'd0, s2_t2_r} << 17)
        - {1'b0, s2_t3_r, 1'b0} + (50'd1 << 31);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
    s1_tag_r <= in_tag;
    s1_t_r   <= in_t;
    s1_t2_r  <= 32'(in_t) * 32'(in_t);
    s2_tag_r <= s1_tag_r;
    s2_t2_r  <= s1_t2_r;
    s2_t3_r  <= 48'(s1_t2_r) * 48'(s1_t_r);
    s3_tag_r <= s2_tag_r;
    s3_w_r   <= v[48:32];
  end

  assign out_vld = s3_vld_r;
  assign out_tag = s3_tag_r;
  assign out_w   = s3_w_r;

endmodule

/* hw/rtl/gnos_dot.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnos_dot
// Corner gradient dot product, two stages, rounded half up to Q.16.
// ----------------------------------------------------------------------------
module gnos_dot (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_vld,
  input  logic [2:0]                          corner,  // bit0 x, bit1 y, bit2 z
  input  gnos_pkg::grad_t                     grad,
  input  logic [gnos_pkg::FRAC_W-1:0]         fx,
  input  logic [gnos_pkg::FRAC_W-1:0]         fy,
  input  logic [gnos_pkg::FRAC_W-1:0]         fz,
  output logic                                out_vld,
  output logic signed [gnos_pkg::CORNER_W-1:0] out_val
);

  logic signed [16:0] dx, dy, dz;
  logic signed [32:0] p0_r, p1_r, p2_r;
  logic               s1_vld_r, s2_vld_r;
  logic signed [34:0] dsum;
  logic signed [gnos_pkg::CORNER_W-1:0] val_r;

  // far-side offset f - 1 is the fraction with a set sign bit
  assign dx = $signed({corner[0], fx});
  assign dy = $signed({corner[1], fy});
  assign dz = $signed({corner[2], fz});

  always_comb begin
    dsum = 35'(p0_r) + 35'(p1_r) + 35'(p2_r) + 35'sd16384;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
    end
    // full-width signed products
    p0_r  <= grad.gx * dx;
    p1_r  <= grad.gy * dy;
    p2_r  <= grad.gz * dz;
    val_r <= dsum[15+gnos_pkg::CORNER_W-1:15];
  end

  assign out_vld = s2_vld_r;
  assign out_val = val_r;

endmodule

/* hw/rtl/gnos_blend.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnos_blend
// Lerp unit, three stages: a + round_half_up((b - a) * w / 2^16).
// ----------------------------------------------------------------------------
module gnos_blend (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_vld,
  input  logic signed [gnos_pkg::CORNER_W-1:0] a,
  input  logic signed [gnos_pkg::CORNER_W-1:0] b,
  input  logic [gnos_pkg::WGT_W-1:0]           w,
  output logic                                 out_vld,
  output logic signed [gnos_pkg::CORNER_W-1:0] out_val
);

  localparam int CW = gnos_pkg::CORNER_W;

  logic              s1_vld_r, s2_vld_r, s3_vld_r;
  logic signed [CW:0]   s1_diff_r;
  logic signed [CW-1:0] s1_a_r, s2_a_r, s3_val_r;
  logic [gnos_pkg::WGT_W-1:0] s1_w_r;
  logic signed [CW+18:0] s2_prod_r;
  logic signed [CW+18:0] rnd;
  logic signed [CW+2:0]  sum;

  always_comb begin
    rnd = s2_prod_r + (39'sd1 <<< 15);
    sum = rnd[CW+18:16] + (CW+3)'(s2_a_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
    s1_diff_r <= (CW+1)'(b) - (CW+1)'(a);
    s1_a_r    <= a;
    s1_w_r    <= w;
    s2_prod_r <= s1_diff_r * $signed({1'b0, s1_w_r});
    s2_a_r    <= s1_a_r;
    s3_val_r  <= sum[CW-1:0];
  end

  assign out_vld = s3_vld_r;
  assign out_val = s3_val_r;

endmodule

/* hw/rtl/gradient_noise_octave_sum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_noise_octave_sum
// 3-D gradient noise with turbulence, fractal or single-octave summation.
// Loads can follow back to back.
// An evaluate of n octaves runs, per octave, 22 chained table reads, the dot
// pipeline, then seven lerps through one shared blend unit; the next item is
// taken only after its result is registered.
// A result held by out_tready stalls the next item; one item is in work at a time.
// Synchronous active-low reset clears control state; tables are unset until loaded.
// ----------------------------------------------------------------------------
module gradient_noise_octave_sum (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // opcode[1:0], table_index[9:2], perm_value[17:10], grad_x[33:18],
  // grad_y[49:34], grad_z[65:50], point_x[97:66], point_y[129:98],
  // point_z[161:130], zero pad
  input  logic [167:0]                in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // noise_value[23:0]
  output logic [23:0]                 out_tdata,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [gnos_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int CW = gnos_pkg::CORNER_W;
  localparam int AW = gnos_pkg::TBL_AW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_OCT  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam logic [4:0] LK_PERM_END = 5'd14;
  localparam logic [4:0] LK_END      = 5'd22;

  // input fields
  logic [1:0]  opcode;
  logic [7:0]  table_index;
  logic [7:0]  perm_value;
  logic [15:0] grad_x, grad_y, grad_z;
  logic [31:0] point_x, point_y, point_z;

  assign opcode      = in_tdata[1:0];
  assign table_index = in_tdata[9:2];
  assign perm_value  = in_tdata[17:10];
  assign grad_x      = in_tdata[33:18];
  assign grad_y      = in_tdata[49:34];
  assign grad_z      = in_tdata[65:50];
  assign point_x     = in_tdata[97:66];
  assign point_y     = in_tdata[129:98];
  assign point_z     = in_tdata[161:130];

  logic [gnos_pkg::OCT_W-1:0] oct_cnt_r;
  logic [1:0]                 sum_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_cnt_r  <= gnos_pkg::OCT_W'(3);
      sum_mode_r <= gnos_pkg::MODE_TURB;
    end else if (cfg_we) begin
      case (cfg_index)
        gnos_pkg::CFG_OCT_COUNT: oct_cnt_r  <= cfg_wdata;
        gnos_pkg::CFG_SUM_MODE:  sum_mode_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  logic [1:0] state_r;
  logic       in_acc;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // table write port
  gnos_pkg::tbl_wr_t tbl_wr;
  always_comb begin
    tbl_wr.perm_we  = in_acc && (opcode == gnos_pkg::OP_LOAD_PERM);
    tbl_wr.grad_we  = in_acc && (opcode == gnos_pkg::OP_LOAD_GRAD);
    tbl_wr.addr     = table_index;
    tbl_wr.perm_val = perm_value;
    tbl_wr.grad.gx  = $signed(grad_x);
    tbl_wr.grad.gy  = $signed(grad_y);
    tbl_wr.grad.gz  = $signed(grad_z);
  end

  logic [AW-1:0]              perm_raddr, grad_raddr;
  logic [gnos_pkg::PERM_W-1:0] perm_rdata;
  gnos_pkg::grad_t            grad_rdata;

  gnos_tables u_tables (
    .clk        (clk),
    .wr         (tbl_wr),
    .perm_raddr (perm_raddr),
    .perm_rdata (perm_rdata),
    .grad_raddr (grad_raddr),
    .grad_rdata (grad_rdata)
  );

  // point registers, scaled by one octave per shift
  logic [gnos_pkg::PT_W-1:0] px_r, py_r, pz_r;
  logic [AW-1:0]             ix, iy, iz;
  logic [15:0]               fx, fy, fz;

  assign ix = px_r[23:16];
  assign iy = py_r[23:16];
  assign iz = pz_r[23:16];
  assign fx = px_r[15:0];
  assign fy = py_r[15:0];
  assign fz = pz_r[15:0];

  // lookup sequencer
  logic [4:0]    lk_r;
  logic          cap_vld_r;
  logic [4:0]    cap_step_r;
  logic [AW-1:0] a_r [2];
  logic [AW-1:0] b_r [4];
  logic [AW-1:0] c_r [8];
  logic          lk_run;
  logic [1:0]    lk_m;
  logic [2:0]    lk_j, lk_g;
  logic [4:0]    lk_m5, lk_j5, lk_g5;

  assign lk_run = (state_r == ST_OCT) && (lk_r < LK_END);
  assign lk_m5  = lk_r - 5'd2;
  assign lk_j5  = lk_r - 5'd6;
  assign lk_g5  = lk_r - LK_PERM_END;
  assign lk_m   = lk_m5[1:0];
  assign lk_j   = lk_j5[2:0];
  assign lk_g   = lk_g5[2:0];

  always_comb begin
    if (lk_r < 5'd2) begin
      perm_raddr = ix + AW'(lk_r[0]);
    end else if (lk_r < 5'd6) begin
      perm_raddr = a_r[lk_m[1]] + iy + AW'(lk_m[0]);
    end else begin
      perm_raddr = b_r[{lk_j[0], lk_j[1]}] + iz + AW'(lk_j[2]);
    end
    grad_raddr = c_r[lk_g];
  end

  logic [4:0] cs_b5, cs_c5, cs_g5;
  assign cs_b5 = cap_step_r - 5'd2;
  assign cs_c5 = cap_step_r - 5'd6;
  assign cs_g5 = cap_step_r - LK_PERM_END;

  always_ff @(posedge clk) begin
    if (cap_vld_r) begin
      if (cap_step_r < 5'd2) begin
        a_r[cap_step_r[0]] <= perm_rdata;
      end else if (cap_step_r < 5'd6) begin
        b_r[cs_b5[1:0]] <= perm_rdata;
      end else if (cap_step_r < LK_PERM_END) begin
        c_r[cs_c5[2:0]] <= perm_rdata;
      end
    end
  end

  // smoothstep weights
  logic                       wt_vld;
  logic [1:0]                 wt_tag;
  logic [gnos_pkg::WGT_W-1:0] wt_w;
  logic [15:0]                wt_t;
  logic [gnos_pkg::WGT_W-1:0] wx_r, wy_r, wz_r;

  assign wt_t = (lk_r == 5'd0) ? fx : ((lk_r == 5'd1) ? fy : fz);

  gnos_weight u_weight (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (lk_run && (lk_r < 5'd3)),
    .in_tag  (lk_r[1:0]),
    .in_t    (wt_t),
    .out_vld (wt_vld),
    .out_tag (wt_tag),
    .out_w   (wt_w)
  );

  always_ff @(posedge clk) begin
    if (wt_vld) begin
      case (wt_tag)
        2'd0:    wx_r <= wt_w;
        2'd1:    wy_r <= wt_w;
        default: wz_r <= wt_w;
      endcase
    end
  end

  // corner dot products
  logic                 dot_vld;
  logic signed [CW-1:0] dot_val;

  gnos_dot u_dot (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (cap_vld_r && (cap_step_r >= LK_PERM_END)),
    .corner  (cs_g5[2:0]),
    .grad    (grad_rdata),
    .fx      (fx),
    .fy      (fy),
    .fz      (fz),
    .out_vld (dot_vld),
    .out_val (dot_val)
  );

  // value queue: corners in x-fastest order, lerp pops two and pushes one
  logic signed [CW-1:0] q_r [8];
  logic [3:0]           qcnt_r;
  logic [3:0]           nc_r;
  logic [2:0]           bo_r;
  logic                 bl_busy_r;
  logic                 bl_issue;
  logic                 bl_vld;
  logic signed [CW-1:0] bl_val;
  logic [gnos_pkg::WGT_W-1:0] bl_w;
  logic                 oct_done;

  assign bl_issue = (state_r == ST_OCT) && (nc_r == 4'd8) && !bl_busy_r
                    && (qcnt_r >= 4'd2);
  assign bl_w     = (bo_r < 3'd4) ? wx_r : ((bo_r < 3'd6) ? wy_r : wz_r);
  assign oct_done = bl_vld && (bo_r == 3'd7);

  gnos_blend u_blend (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (bl_issue),
    .a       (q_r[0]),
    .b       (q_r[1]),
    .w       (bl_w),
    .out_vld (bl_vld),
    .out_val (bl_val)
  );

  always_ff @(posedge clk) begin
    if (bl_issue) begin
      for (int k = 0; k < 6; k++) begin
        q_r[k] <= q_r[k+2];
      end
    end else if (dot_vld || (bl_vld && !oct_done)) begin
      q_r[qcnt_r[2:0]] <= dot_vld ? dot_val : bl_val;
    end
  end

  // octave accumulation
  logic [gnos_pkg::OCT_IDX_W-1:0] oct_r;
  logic [gnos_pkg::OCT_W-1:0]     n_r, n_eval;
  logic signed [gnos_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [gnos_pkg::TERM_W-1:0] term;
  logic                           last_oct;

  always_comb begin
    if (sum_mode_r == gnos_pkg::MODE_TURB) begin
      term = bl_val[CW-1] ? -gnos_pkg::TERM_W'(bl_val) : gnos_pkg::TERM_W'(bl_val);
    end else if (sum_mode_r == gnos_pkg::MODE_FRACTAL) begin
      term = (gnos_pkg::TERM_W'(bl_val) <<< 1) - 22'sd65536;
    end else begin
      term = gnos_pkg::TERM_W'(bl_val);
    end
    acc_nxt = acc_r + (gnos_pkg::ACC_W'(term) <<< (~oct_r));
    if (sum_mode_r > gnos_pkg::MODE_FRACTAL) begin
      n_eval = gnos_pkg::OCT_W'(1);
    end else if (oct_cnt_r > gnos_pkg::OCT_W'(gnos_pkg::MAX_OCT)) begin
      n_eval = gnos_pkg::OCT_W'(gnos_pkg::MAX_OCT);
    end else begin
      n_eval = oct_cnt_r;
    end
  end

  assign last_oct = (gnos_pkg::OCT_W'(oct_r) + gnos_pkg::OCT_W'(1)) == n_r;

  // final rounding and clamp
  logic signed [gnos_pkg::ACC_W-1:0] rnd_acc;
  logic signed [gnos_pkg::ACC_W-8:0] res_full;
  logic [gnos_pkg::RES_W-1:0]        res;

  always_comb begin
    rnd_acc  = acc_r + 34'sd64;
    res_full = rnd_acc[gnos_pkg::ACC_W-1:7];
    if (res_full > 27'sd8388607) begin
      res = 24'h7FFFFF;
    end else if (res_full < -27'sd8388608) begin
      res = 24'h800000;
    end else begin
      res = res_full[gnos_pkg::RES_W-1:0];
    end
  end

  logic                       out_vld_r;
  logic [gnos_pkg::RES_W-1:0] out_data_r;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
      lk_r      <= LK_END;
      cap_vld_r <= 1'b0;
      nc_r      <= 4'd0;
      qcnt_r    <= 4'd0;
      bo_r      <= 3'd0;
      bl_busy_r <= 1'b0;
      oct_r     <= '0;
    end else begin
      cap_vld_r  <= lk_run;
      cap_step_r <= lk_r;
      if (lk_run) begin
        lk_r <= lk_r + 5'd1;
      end
      if ((state_r == ST_FIN) && (!out_vld_r || out_tready)) begin
        out_vld_r <= 1'b1;
      end else if (out_vld_r && out_tready) begin
        out_vld_r <= 1'b0;
      end

      // queue bookkeeping
      if (bl_issue) begin
        qcnt_r    <= qcnt_r - 4'd2;
        bl_busy_r <= 1'b1;
        bo_r      <= bo_r + 3'd1;
      end else if (dot_vld) begin
        qcnt_r <= qcnt_r + 4'd1;
        nc_r   <= nc_r + 4'd1;
      end else if (bl_vld) begin
        if (!oct_done) begin
          qcnt_r <= qcnt_r + 4'd1;
        end
        bl_busy_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc && (opcode == gnos_pkg::OP_EVAL)) begin
            px_r  <= point_x[gnos_pkg::PT_W-1:0];
            py_r  <= point_y[gnos_pkg::PT_W-1:0];
            pz_r  <= point_z[gnos_pkg::PT_W-1:0];
            acc_r <= '0;
            oct_r <= '0;
            n_r   <= n_eval;
            if (n_eval == '0) begin
              state_r <= ST_FIN;
            end else begin
              state_r <= ST_OCT;
              lk_r    <= 5'd0;
              nc_r    <= 4'd0;
              qcnt_r  <= 4'd0;
              bo_r    <= 3'd0;
            end
          end
        end
        ST_OCT: begin
          if (oct_done) begin
            acc_r <= acc_nxt;
            if (last_oct) begin
              state_r <= ST_FIN;
            end else begin
              // advance to the next octave at double frequency
              oct_r  <= oct_r + 1'b1;
              px_r   <= px_r << 1;
              py_r   <= py_r << 1;
              pz_r   <= pz_r << 1;
              lk_r   <= 5'd0;
              nc_r   <= 4'd0;
              qcnt_r <= 4'd0;
              bo_r   <= 3'd0;
            end
          end
        end
        ST_FIN: begin
          if (!out_vld_r || out_tready) begin
            out_data_r <= res;
            state_r    <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

/* sim/gnos_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnos_checker
// Watches the input, result and register ports of the noise block, keeps its
// own copy of the tables and registers, predicts every noise value and
// compares each result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module gnos_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [167:0]               in_tdata,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [23:0]                out_tdata,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [gnos_pkg::CFG_W-1:0] cfg_wdata,
  output int                         err_count,
  output int                         pending
);

  logic [7:0]         perm_tbl [256];
  logic signed [15:0] grad_tbl [256][3];
  logic [3:0]         oct_count;
  logic [1:0]         sum_mode;
  logic [23:0]        noise_q[$];

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint corner_dot(longint x, longint y, longint z,
                                        longint dx, longint dy, longint dz);
    logic [7:0] a, b, c;
    longint     dot;
    a = perm_tbl[x[7:0]];
    b = perm_tbl[8'(a + y[7:0])];
    c = perm_tbl[8'(b + z[7:0])];
    dot = longint'(grad_tbl[c][0]) * dx + longint'(grad_tbl[c][1]) * dy
        + longint'(grad_tbl[c][2]) * dz;
    return rnd_shift(dot, 15);
  endfunction

  function automatic longint smooth_wgt(longint t);
    longint unsigned v;
    v = 3 * t * t * 65536 - 2 * t * t * t;
    return longint'((v + (64'd1 << 31)) >> 32);
  endfunction

  function automatic longint lerp(longint a, longint b, longint w);
    return a + rnd_shift((b - a) * w, 16);
  endfunction

  function automatic longint noise_pred(longint px, longint py, longint pz);
    longint ix, iy, iz, fx, fy, fz, gx, gy, gz, wx, wy, wz;
    longint c000, c100, c010, c110, c001, c101, c011, c111;
    longint e00, e10, e01, e11, f0, f1;
    ix = (px >> 16) & 255; iy = (py >> 16) & 255; iz = (pz >> 16) & 255;
    fx = px & 16'hFFFF; fy = py & 16'hFFFF; fz = pz & 16'hFFFF;
    gx = fx - 65536; gy = fy - 65536; gz = fz - 65536;
    c000 = corner_dot(ix,     iy,     iz,     fx, fy, fz);
    c100 = corner_dot(ix + 1, iy,     iz,     gx, fy, fz);
    c010 = corner_dot(ix,     iy + 1, iz,     fx, gy, fz);
    c110 = corner_dot(ix + 1, iy + 1, iz,     gx, gy, fz);
    c001 = corner_dot(ix,     iy,     iz + 1, fx, fy, gz);
    c101 = corner_dot(ix + 1, iy,     iz + 1, gx, fy, gz);
    c011 = corner_dot(ix,     iy + 1, iz + 1, fx, gy, gz);
    c111 = corner_dot(ix + 1, iy + 1, iz + 1, gx, gy, gz);
    wx = smooth_wgt(fx); wy = smooth_wgt(fy); wz = smooth_wgt(fz);
    e00 = lerp(c000, c100, wx);
    e10 = lerp(c010, c110, wx);
    e01 = lerp(c001, c101, wx);
    e11 = lerp(c011, c111, wx);
    f0  = lerp(e00, e10, wy);
    f1  = lerp(e01, e11, wy);
    return lerp(f0, f1, wz);
  endfunction

  function automatic logic [23:0] octave_sum(longint px, longint py, longint pz);
    longint acc, res, v, term;
    int     n;
    acc = 0;
    if (sum_mode != gnos_pkg::MODE_TURB && sum_mode != gnos_pkg::MODE_FRACTAL) begin
      res = noise_pred(px, py, pz);
    end else begin
      n = (oct_count > gnos_pkg::MAX_OCT) ? gnos_pkg::MAX_OCT : oct_count;
      for (int i = 0; i < n; i++) begin
        v = noise_pred(px << i, py << i, pz << i);
        term = (sum_mode == gnos_pkg::MODE_TURB) ? ((v < 0) ? -v : v)
                                                 : 2 * v - 65536;
        acc += term << (gnos_pkg::MAX_OCT - 1 - i);
      end
      res = rnd_shift(acc, gnos_pkg::MAX_OCT - 1);
    end
    if (res > 8388607) res = 8388607;
    if (res < -8388608) res = -8388608;
    return res[23:0];
  endfunction

  task automatic report(input string what, input logic [23:0] got,
                        input logic [23:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    err_count++;
  endtask

  initial begin
    err_count = 0;
    pending   = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      oct_count = 4'd3;
      sum_mode  = gnos_pkg::MODE_TURB;
      noise_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == gnos_pkg::CFG_OCT_COUNT) oct_count = cfg_wdata;
        else sum_mode = cfg_wdata[1:0];
      end
      if (in_tvalid && in_tready) begin
        case (in_tdata[1:0])
          gnos_pkg::OP_LOAD_PERM: perm_tbl[in_tdata[9:2]] = in_tdata[17:10];
          gnos_pkg::OP_LOAD_GRAD: begin
            grad_tbl[in_tdata[9:2]][0] = in_tdata[33:18];
            grad_tbl[in_tdata[9:2]][1] = in_tdata[49:34];
            grad_tbl[in_tdata[9:2]][2] = in_tdata[65:50];
          end
          gnos_pkg::OP_EVAL: noise_q.push_back(octave_sum(
                     longint'(signed'(in_tdata[97:66])),
                     longint'(signed'(in_tdata[129:98])),
                     longint'(signed'(in_tdata[161:130]))));
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (noise_q.size() == 0) report("unexpected result", out_tdata, 24'h0);
        else if (out_tdata !== noise_q[0]) begin
          report("noise_value", out_tdata, noise_q[0]);
          void'(noise_q.pop_front());
        end else begin
          void'(noise_q.pop_front());
        end
      end
    end
    pending = noise_q.size();
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the gradient noise block: fills both tables, walks through
// several octave counts and sum modes with directed and random points, mixes
// in table reloads and ignored items, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module tb;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_tvalid = 1'b0;
  logic                        in_tready;
  logic [167:0]                in_tdata = '0;
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [23:0]                 out_tdata;
  logic                        cfg_we = 1'b0;
  logic                        cfg_index = 1'b0;
  logic [gnos_pkg::CFG_W-1:0]  cfg_wdata = '0;
  int                          err_count;
  int                          pending;
  bit                          calm = 1'b0;

  always #5 clk = ~clk;

  gradient_noise_octave_sum dut (.*);
  gnos_checker chk (.*);

  initial begin
    #40ms;
    $display("tb failed");
    $finish;
  end

  // random ready bursts on the result side
  always @(negedge clk) begin
    if (!calm && $urandom_range(0, 5) == 0) begin
      out_tready = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    out_tready = 1'b1;
  end

  function automatic logic [167:0] pack(logic [1:0] op, logic [7:0] idx,
      logic [7:0] pv, logic [15:0] gx, logic [15:0] gy, logic [15:0] gz,
      logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    return {6'd0, pz, py, px, gz, gy, gx, pv, idx, op};
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send(input logic [167:0] d);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = d;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic set_regs(input logic [3:0] oc, input logic [1:0] md);
    while (pending != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    cfg_we = 1'b1; cfg_index = gnos_pkg::CFG_OCT_COUNT; cfg_wdata = oc;
    @(negedge clk);
    cfg_index = gnos_pkg::CFG_SUM_MODE; cfg_wdata = gnos_pkg::CFG_W'(md);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic eval_pt(input logic [31:0] px, input logic [31:0] py,
                         input logic [31:0] pz);
    send(pack(gnos_pkg::OP_EVAL, 8'($urandom), 8'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom), px, py, pz));
  endtask

  function automatic logic [31:0] rnd_point();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      2:       return {16'($urandom_range(0, 1023) - 512), 16'($urandom)};
      default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                       $urandom_range(0, 1) ? 16'hFFFF : 16'h0000};
    endcase
  endfunction

  function automatic logic [15:0] rnd_grad();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  logic [3:0] oc_list [12] = '{4'd3, 4'd1, 4'd8, 4'd0, 4'd15, 4'd8,
                               4'd1, 4'd0, 4'd5, 4'd8, 4'd9, 4'd7};
  logic [1:0] md_list [12] = '{gnos_pkg::MODE_TURB, gnos_pkg::MODE_TURB,
                               gnos_pkg::MODE_TURB, gnos_pkg::MODE_TURB,
                               gnos_pkg::MODE_FRACTAL, gnos_pkg::MODE_FRACTAL,
                               gnos_pkg::MODE_FRACTAL, gnos_pkg::MODE_FRACTAL,
                               gnos_pkg::MODE_SINGLE, gnos_pkg::MODE_SPARE,
                               gnos_pkg::MODE_TURB, gnos_pkg::MODE_FRACTAL};

  initial begin
    int op_pick;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // fill both tables before any lookup can happen
    for (int i = 0; i < 256; i++)
      send(pack(gnos_pkg::OP_LOAD_PERM, 8'(i), (i < 2) ? 8'(i * 255) : 8'($urandom),
                '0, '0, '0, '0, '0, '0));
    for (int i = 0; i < 256; i++)
      send(pack(gnos_pkg::OP_LOAD_GRAD, 8'(i), '0, rnd_grad(), rnd_grad(), rnd_grad(),
                '0, '0, '0));
    // directed: point extremes, fraction edges, ignored opcode, extreme gradients
    eval_pt(32'h0, 32'h0, 32'h0);
    eval_pt(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    eval_pt(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    eval_pt(32'hFFFF_FFFF, 32'h0000_FFFF, 32'h8000_FFFF);
    eval_pt(32'h0000_8000, 32'h0001_0000, 32'hFFFF_0001);
    eval_pt(32'h00FF_FFFF, 32'h00FF_0000, 32'h0100_0000);
    send(pack(gnos_pkg::OP_SPARE, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send(pack(gnos_pkg::OP_LOAD_GRAD, 8'd0, '0, 16'h8000, 16'h8000, 16'h8000,
              '0, '0, '0));
    send(pack(gnos_pkg::OP_LOAD_GRAD, 8'd255, '0, 16'h7FFF, 16'h7FFF, 16'h7FFF,
              '0, '0, '0));
    eval_pt(32'h0000_7FFF, 32'h0000_7FFF, 32'h0000_7FFF);
    // phases over several register settings
    for (int ph = 0; ph < 12; ph++) begin
      set_regs(oc_list[ph], md_list[ph]);
      if (ph == 11) calm = 1'b1;
      for (int k = 0; k < 95; k++) begin
        op_pick = $urandom_range(0, 19);
        if (op_pick < 14)
          eval_pt(rnd_point(), rnd_point(), rnd_point());
        else if (op_pick < 16)
          send(pack(gnos_pkg::OP_LOAD_PERM, 8'($urandom), 8'($urandom),
                    '0, '0, '0, '0, '0, '0));
        else if (op_pick < 19)
          send(pack(gnos_pkg::OP_LOAD_GRAD, 8'($urandom), '0, rnd_grad(), rnd_grad(),
                    rnd_grad(), '0, '0, '0));
        else
          send(pack(gnos_pkg::OP_SPARE, 8'($urandom), 8'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), $urandom, $urandom, $urandom));
      end
    end
    while (pending != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    if (err_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/gnos_pkg.sv
hw/rtl/gnos_tables.sv
hw/rtl/gnos_weight.sv
hw/rtl/gnos_dot.sv
hw/rtl/gnos_blend.sv
hw/rtl/gradient_noise_octave_sum.sv
sim/gnos_checker.sv
sim/tb.sv
